### design/mttl_pkg.sv
// ----------------------------------------------------------------------------
// mttl_pkg
// Types and constants shared by the thermal torque limiter modules.
// ----------------------------------------------------------------------------
package mttl_pkg;

	typedef struct packed {
		logic               op;
		logic [4:0]         joint;
		logic signed [15:0] temperature;
		logic signed [15:0] limit_temperature;
		logic signed [15:0] ambient_temperature;
		logic signed [31:0] current_coeff;
		logic signed [31:0] thermo_coeff;
		logic [31:0]        default_torque;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  joint_out;
		logic [31:0] torque_max;
		logic        used_default;
		logic        frame_done;
		logic [15:0] peak_ratio_out;
		logic [1:0]  beep_mode;
		logic [11:0] beep_freq;
		logic [8:0]  beep_duration;
	} out_item_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] BEEP_NONE      = 2'd0;
	localparam logic [1:0] BEEP_STOP      = 2'd1;
	localparam logic [1:0] BEEP_WARNING   = 2'd2;
	localparam logic [1:0] BEEP_EMERGENCY = 2'd3;

	localparam logic [0:0] CFG_JOINT_COUNT = 1'b0;
	localparam logic [0:0] CFG_WARN_LEVEL  = 1'b1;

	localparam logic [11:0] FREQ_EMERG_HI = 12'd4000;
	localparam logic [11:0] FREQ_EMERG_LO = 12'd2000;
	localparam logic [11:0] FREQ_WARN_LO  = 12'd2794;
	localparam logic [8:0]  DUR_EMERG     = 9'd60;
	localparam logic [8:0]  DUR_WARN      = 9'd500;
	localparam logic [15:0] RATIO_ONE     = 16'd4096;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture item, read tables
		logic prep;     // form numerator, divisor, ratio operands
		logic mul_a;    // 120*kc and 120*|cc|
		logic mul_b;    // *(t-amb)
		logic div_init; // start torque divide
		logic div_step;
		logic rdiv_init;
		logic rdiv_step;
		logic sqrt_init;
		logic sqrt_step;
		logic wdiv_init;
		logic wdiv_step;
		logic finish;   // build result
	} cmd_t;

endpackage

### design/motor_thermal_torque_limiter.sv
// ----------------------------------------------------------------------------
// motor_thermal_torque_limiter
// Per-joint thermal torque limit with frame peak ratio and beep command.
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------
// in       | in_valid / in_ready  | in_item  (mttl_pkg::in_item_t)
// out      | out_valid / out_ready| out_item (mttl_pkg::out_item_t)
// cfg      | cfg_we               | cfg_index, cfg_data
//
// a load item with an in-range joint is written to the joint tables on accept; a
// sample is accepted only when idle and passes table read, operand prep, two
// multiplies, the 88-step torque divide, 28-step ratio divide, 32-step root,
// 21-step tone divide and the output state; a waiting result holds it there
// reset clears controller, peak and frame phase; joint tables need loading first
// ----------------------------------------------------------------------------
module motor_thermal_torque_limiter #(
	parameter int MAX_JOINTS       = 32,
	parameter int EMERGENCY_PERIOD = 200
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mttl_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mttl_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [11:0]         cfg_data
);
	import mttl_pkg::*;

	cmd_t        cmd;
	logic [5:0]  joint_count_q;
	logic [11:0] warn_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_count_q <= 6'd32;
			warn_level_q  <= 12'd2048;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_JOINT_COUNT: joint_count_q <= cfg_data[5:0];
				CFG_WARN_LEVEL:  warn_level_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mttl_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid, .in_op(in_item.op), .in_ready,
		.out_valid, .out_ready, .cmd
	);

	mttl_dp #(.MAX_JOINTS(MAX_JOINTS), .EMERGENCY_PERIOD(EMERGENCY_PERIOD)) u_dp (
		.clk, .arst_n, .in_item, .cmd,
		.joint_count(joint_count_q), .warn_level(warn_level_q),
		.out_item
	);
endmodule

### design/mttl_ram.sv
// ----------------------------------------------------------------------------
// mttl_ram
// Generic single-port write, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mttl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### design/mttl_ctrl.sv
// ----------------------------------------------------------------------------
// mttl_ctrl
// Sequencer: steps a sample through table read, multiplies, divides and root.
// ----------------------------------------------------------------------------
module mttl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mttl_pkg::cmd_t    cmd
);
	import mttl_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_READ  = 10'b0000000010,
		ST_PREP  = 10'b0000000100,
		ST_MULA  = 10'b0000001000,
		ST_MULB  = 10'b0000010000,
		ST_DIV   = 10'b0000100000,
		ST_RDIV  = 10'b0001000000,
		ST_SQRT  = 10'b0010000000,
		ST_WDIV  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t     state_q;
	logic [6:0] cnt_q;
	logic       out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_ready && in_valid;
		case (state_q)
			ST_READ: cmd.prep = 1'b1;
			ST_PREP: cmd.mul_a = 1'b1;
			ST_MULA: cmd.mul_b = 1'b1;
			ST_MULB: begin
				cmd.div_init  = 1'b1;
				cmd.rdiv_init = 1'b1;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_RDIV: begin
				cmd.rdiv_step = 1'b1;
				cmd.sqrt_init = (cnt_q == 7'd0);
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cmd.wdiv_init = (cnt_q == 7'd0);
			end
			ST_WDIV: cmd.wdiv_step = 1'b1;
			ST_OUT: cmd.finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load && in_op == OP_SAMPLE) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_MULA;
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: begin
					state_q <= ST_DIV;
					cnt_q   <= 7'd87;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						state_q <= ST_RDIV;
						cnt_q   <= 7'd27;
					end
				end
				ST_RDIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						state_q <= ST_SQRT;
						cnt_q   <= 7'd31;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						state_q <= ST_WDIV;
						cnt_q   <= 7'd20;
					end
				end
				ST_WDIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### design/mttl_dp.sv
// ----------------------------------------------------------------------------
// mttl_dp
// Datapath: joint tables, multiplier, restoring dividers, bitwise root.
// ----------------------------------------------------------------------------
module mttl_dp #(
	parameter int MAX_JOINTS       = 32,
	parameter int EMERGENCY_PERIOD = 200
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mttl_pkg::in_item_t  in_item,
	input  mttl_pkg::cmd_t      cmd,
	input  logic [5:0]          joint_count,
	input  logic [11:0]         warn_level,
	output mttl_pkg::out_item_t out_item
);
	import mttl_pkg::*;

	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int PW = $clog2(EMERGENCY_PERIOD);
	localparam logic [PW-1:0] PHASE_LAST = PW'(EMERGENCY_PERIOD - 1);
	localparam logic [PW-1:0] PHASE_HALF = PW'(EMERGENCY_PERIOD / 2);

	logic [4:0]         joint_q;
	logic signed [15:0] temp_q;
	logic               ok_q;
	logic               ok_w;
	logic [AW-1:0]      addr_w;
	logic [15:0] lim_rd, amb_rd;
	logic [31:0] cc_rd, kc_rd, fb_rd;
	logic               we_w;

	assign ok_w   = 32'(in_item.joint) < 32'(MAX_JOINTS);
	assign addr_w = AW'(in_item.joint);
	assign we_w   = cmd.load && in_item.op == OP_LOAD && ok_w;

	mttl_ram #(.WIDTH(16), .DEPTH(MAX_JOINTS)) u_lim (.clk, .we(we_w), .waddr(addr_w),
		.wdata(in_item.limit_temperature), .raddr(addr_w), .rdata(lim_rd));
	mttl_ram #(.WIDTH(16), .DEPTH(MAX_JOINTS)) u_amb (.clk, .we(we_w), .waddr(addr_w),
		.wdata(in_item.ambient_temperature), .raddr(addr_w), .rdata(amb_rd));
	mttl_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_cc (.clk, .we(we_w), .waddr(addr_w),
		.wdata(in_item.current_coeff), .raddr(addr_w), .rdata(cc_rd));
	mttl_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_kc (.clk, .we(we_w), .waddr(addr_w),
		.wdata(in_item.thermo_coeff), .raddr(addr_w), .rdata(kc_rd));
	mttl_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_fb (.clk, .we(we_w), .waddr(addr_w),
		.wdata(in_item.default_torque), .raddr(addr_w), .rdata(fb_rd));

	// operands
	logic signed [15:0] lim_q;
	logic signed [31:0] cc_q;
	logic signed [31:0] kc_q;
	logic [31:0]        fb_q;
	logic signed [16:0] tdiff_q;     // t - amb
	logic signed [40:0] num0_q;      // (lim - t) << 24
	logic signed [39:0] kc120_q;
	logic signed [63:0] num_q;
	logic [38:0]        d_q;         // 120*|cc|
	logic [15:0]        rnum_q;      // |t|
	logic [15:0]        rden_q;      // |lim|

	logic signed [39:0] kc_mul;
	logic signed [56:0] prod_b;
	assign kc_mul = 40'(kc_q) * 40'sd120;
	assign prod_b = 57'(kc120_q) * 57'(tdiff_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			joint_q <= in_item.joint;
			temp_q  <= in_item.temperature;
			ok_q    <= ok_w;
		end
		if (cmd.prep) begin
			lim_q   <= ok_q ? lim_rd : '0;
			cc_q    <= ok_q ? cc_rd : '0;
			kc_q    <= ok_q ? kc_rd : '0;
			fb_q    <= ok_q ? fb_rd : '0;
			tdiff_q <= 17'(temp_q) - 17'(signed'(ok_q ? amb_rd : 16'd0));
			num0_q  <= (41'(signed'(ok_q ? lim_rd : 16'd0)) - 41'(temp_q)) <<< 24;
			rnum_q  <= temp_q[15] ? 16'(-temp_q) : temp_q;
			rden_q  <= (ok_q && lim_rd[15]) ? 16'(-lim_rd) : (ok_q ? lim_rd : 16'd0);
		end
		if (cmd.mul_a) begin
			kc120_q <= kc_mul;
			d_q     <= 39'(cc_q[31] ? 33'(-33'(cc_q)) : 33'(cc_q)) * 39'd120;
		end
		if (cmd.mul_b) begin
			num_q <= 64'(num0_q) + 64'(prod_b);
		end
	end

	// torque divide: n / d -> 64-bit quotient then 24 fraction bits
	logic [63:0] n_mag;
	logic        neg_sign, zero_num, use_fb;
	assign n_mag    = num_q[63] ? 64'(-num_q) : num_q;
	assign zero_num = (num_q == '0);
	assign neg_sign = !zero_num && (num_q[63] != cc_q[31]);
	assign use_fb   = (cc_q == '0) || neg_sign;

	logic [87:0] dq_q;     // quotient shifted in
	logic [63:0] dn_q;     // remaining dividend bits
	logic [39:0] dr_q;     // partial remainder
	logic [39:0] dr_sh;
	logic        dge;
	assign dr_sh = {dr_q[38:0], dn_q[63]};
	assign dge   = dr_sh >= 40'(d_q);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dq_q <= '0;
			dn_q <= n_mag;
			dr_q <= '0;
		end else if (cmd.div_step) begin
			dn_q <= {dn_q[62:0], 1'b0};
			dr_q <= dge ? dr_sh - 40'(d_q) : dr_sh;
			dq_q <= {dq_q[86:0], dge};
		end
	end

	// ratio divide: |t| << 12 / |lim|
	logic [31:0] rq_q;
	logic [15:0] rn_q;
	logic [16:0] rr_q;
	logic [16:0] rr_sh;
	logic        rge;
	assign rr_sh = {rr_q[15:0], rn_q[15]};
	assign rge   = rr_sh >= 17'(rden_q);

	always_ff @(posedge clk) begin
		if (cmd.rdiv_init) begin
			rq_q <= '0;
			rn_q <= rnum_q;
			rr_q <= '0;
		end else if (cmd.rdiv_step) begin
			rn_q <= {rn_q[14:0], 1'b0};
			rr_q <= rge ? rr_sh - 17'(rden_q) : rr_sh;
			rq_q <= {rq_q[30:0], rge};
		end
	end

	// root of 64-bit value, one result bit a step
	logic [63:0] sv_q;
	logic [31:0] sres_q;
	logic [33:0] srem_q;
	logic [33:0] srem_sh, strial;
	logic        sge;
	logic        sat_q;
	assign srem_sh = {srem_q[31:0], sv_q[63:62]};
	assign strial  = {sres_q, 2'b01};
	assign sge     = srem_sh >= strial;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sat_q  <= dq_q[87:64] != '0;
			sv_q   <= dq_q[63:0];
			sres_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			sv_q   <= {sv_q[61:0], 2'b00};
			srem_q <= sge ? srem_sh - strial : srem_sh;
			sres_q <= {sres_q[30:0], sge};
		end
	end

	// warning tone divide: 342*(p-level) / (4096-level)
	logic [15:0]     peak_q;
	logic [PW-1:0]   phase_q;
	logic [15:0]     peak_new;
	logic [15:0]     rt_sat;
	logic [5:0]      cnt_eff;
	logic            done_w;
	logic [PW-1:0]   ph_next;
	logic [12:0]     wden;
	logic [20:0]     wnum;
	logic [8:0]      wq_q;
	logic [20:0]     wn_q;
	logic [12:0]     wr_q;
	logic [13:0]     wr_sh;
	logic            wge;

	assign rt_sat   = (rq_q[31:16] != '0) ? 16'hFFFF : rq_q[15:0];
	always_comb begin
		peak_new = peak_q;
		if (rden_q == '0) begin
			if (rnum_q != '0) begin
				peak_new = 16'hFFFF;
			end
		end else if (rt_sat > peak_q) begin
			peak_new = rt_sat;
		end
	end
	assign cnt_eff = (joint_count == '0) ? 6'd1 :
		((32'(joint_count) > 32'(MAX_JOINTS)) ? 6'(MAX_JOINTS) : joint_count);
	assign done_w  = {1'b0, joint_q} == cnt_eff - 6'd1;
	assign ph_next = (phase_q == PHASE_LAST) ? '0 : phase_q + PW'(1);
	assign wden    = 13'd4096 - 13'(warn_level);
	assign wnum    = 21'd342 * 21'(peak_new[12:0] - 13'(warn_level));
	assign wr_sh   = {wr_q, wn_q[20]};
	assign wge     = wr_sh >= 14'(wden);

	always_ff @(posedge clk) begin
		if (cmd.wdiv_init) begin
			wq_q <= '0;
			wn_q <= wnum;
			wr_q <= '0;
		end else if (cmd.wdiv_step) begin
			wn_q <= {wn_q[19:0], 1'b0};
			wr_q <= wge ? 13'(wr_sh - 14'(wden)) : wr_sh[12:0];
			wq_q <= {wq_q[7:0], wge};
		end
	end

	// result, peak and phase
	out_item_t res_q;
	assign out_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			phase_q <= '0;
		end else if (cmd.finish) begin
			peak_q <= done_w ? 16'd0 : peak_new;
			if (done_w) begin
				phase_q <= ph_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.joint_out      <= joint_q;
			res_q.used_default   <= use_fb;
			res_q.frame_done     <= done_w;
			res_q.peak_ratio_out <= peak_new;
			if (use_fb) begin
				res_q.torque_max <= fb_q;
			end else if (zero_num) begin
				res_q.torque_max <= '0;
			end else if (sat_q) begin
				res_q.torque_max <= '1;
			end else begin
				res_q.torque_max <= sres_q;
			end
			res_q.beep_mode     <= BEEP_NONE;
			res_q.beep_freq     <= '0;
			res_q.beep_duration <= '0;
			if (done_w) begin
				if (peak_new > RATIO_ONE) begin
					res_q.beep_mode     <= BEEP_EMERGENCY;
					res_q.beep_duration <= DUR_EMERG;
					res_q.beep_freq     <= (ph_next <= PHASE_HALF) ? FREQ_EMERG_HI
						: FREQ_EMERG_LO;
				end else if (peak_new > 16'(warn_level)) begin
					res_q.beep_mode     <= BEEP_WARNING;
					res_q.beep_duration <= DUR_WARN;
					res_q.beep_freq     <= FREQ_WARN_LO + 12'(wq_q);
				end else begin
					res_q.beep_mode <= BEEP_STOP;
				end
			end
		end
	end
endmodule
